[hw/rtl/tsl_pkg.sv]
package tsl_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] CFG_BLOCK_LOG2  = 3'd0;
    localparam logic [2:0] CFG_BYTES_BLOCK = 3'd1;
    localparam logic [2:0] CFG_WIDTH       = 3'd2;
    localparam logic [2:0] CFG_HEIGHT      = 3'd3;
    localparam logic [2:0] CFG_DEPTH       = 3'd4;
    localparam logic [2:0] CFG_MIP_LEVELS  = 3'd5;
    localparam logic [2:0] CFG_FACE_COUNT  = 3'd6;
    localparam logic [2:0] CFG_ARRAY_SIZE  = 3'd7;

    // block size code with no matching format
    localparam logic [1:0] BLOCK_LOG2_UNKNOWN = 2'd3;

    // texture description plus its validity flag
    typedef struct packed {
        logic [1:0]  block_log2;
        logic [4:0]  bpb;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] depth;
        logic [4:0]  mip_levels;
        logic [2:0]  face_count;
        logic [11:0] array_size;
        logic        layout_ok;
    } t_cfg;

    // request to the shared multiplier
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [15:0] b;
    } t_mul_req;

    // multiplier response: full 80-bit product
    typedef struct packed {
        logic        done;
        logic [79:0] p;
    } t_mul_rsp;

    typedef enum logic [1:0] {
        M_IDLE,
        M_LO,
        M_HI,
        M_SUM
    } t_mul_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_L_BPB,
        S_L_BY,
        S_L_D,
        S_CNT,
        S_TOT,
        S_IDX,
        S_OFF,
        S_FIN
    } t_state;

    // mip extent: max(1, base >> m)
    function automatic logic [15:0] tsl_extent(input logic [15:0] base, input logic [5:0] m);
        logic [15:0] v;
        v = base >> m;
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    // extent in blocks, rounded up
    function automatic logic [15:0] tsl_blocks(input logic [15:0] ext, input logic [1:0] bl);
        logic [16:0] round;
        logic [16:0] sum;
        round = (17'd1 << bl) - 17'd1;
        sum   = {1'b0, ext} + round;
        return 16'(sum >> bl);
    endfunction

endpackage

[hw/rtl/tsl_cfg.sv]
module tsl_cfg
    import tsl_pkg::*;
#(
    parameter int MAX_MIP_LEVELS = 17
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    // register file, written by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_log2 <= 2'd0;
            r_cfg.bpb        <= 5'd4;
            r_cfg.width      <= 16'd1;
            r_cfg.height     <= 16'd1;
            r_cfg.depth      <= 16'd1;
            r_cfg.mip_levels <= 5'd1;
            r_cfg.face_count <= 3'd1;
            r_cfg.array_size <= 12'd1;
            r_cfg.layout_ok  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_BLOCK_LOG2:  r_cfg.block_log2 <= i_cfg_data[1:0];
                CFG_BYTES_BLOCK: r_cfg.bpb        <= i_cfg_data[4:0];
                CFG_WIDTH:       r_cfg.width      <= i_cfg_data;
                CFG_HEIGHT:      r_cfg.height     <= i_cfg_data;
                CFG_DEPTH:       r_cfg.depth      <= i_cfg_data;
                CFG_MIP_LEVELS:  r_cfg.mip_levels <= i_cfg_data[4:0];
                CFG_FACE_COUNT:  r_cfg.face_count <= i_cfg_data[2:0];
                CFG_ARRAY_SIZE:  r_cfg.array_size <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // layout check on the settings alone; overflow is found later
    always_comb begin
        o_cfg = r_cfg;
        o_cfg.layout_ok = (r_cfg.bpb != 5'd0) && (r_cfg.block_log2 != BLOCK_LOG2_UNKNOWN) &&
                          (r_cfg.width != 16'd0) && (r_cfg.height != 16'd0) &&
                          (r_cfg.depth != 16'd0) && (r_cfg.mip_levels != 5'd0) &&
                          ({1'b0, r_cfg.mip_levels} <= 6'(MAX_MIP_LEVELS)) &&
                          (r_cfg.face_count != 3'd0) && (r_cfg.array_size != 12'd0);
    end

endmodule

[hw/rtl/tsl_mul.sv]
module tsl_mul
    import tsl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    t_mul_phase  r_phase;
    t_mul_phase  n_phase;
    logic        r_done;
    logic [63:0] r_a;
    logic [15:0] r_b;
    logic [47:0] r_lo;
    logic [47:0] r_hi;
    logic [79:0] r_p;

    // phase sequence: low half, high half, sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == M_SUM);
        end
    end

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            M_IDLE:  if (i_req.start) n_phase = M_LO;
            M_LO:    n_phase = M_HI;
            M_HI:    n_phase = M_SUM;
            M_SUM:   n_phase = M_IDLE;
            default: n_phase = M_IDLE;
        endcase
    end

    // one 32x16 multiplier, used twice per request
    always_ff @(posedge i_clk) begin
        if (r_phase == M_IDLE && i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end
        case (r_phase)
            M_LO:  r_lo <= 48'(r_a[31:0]) * 48'(r_b);
            M_HI:  r_hi <= 48'(r_a[63:32]) * 48'(r_b);
            M_SUM: r_p  <= {r_hi, 32'd0} + {32'd0, r_lo};
            default: ;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_p;

endmodule

[hw/rtl/texture_subresource_layout_core.sv]
// For a valid layout an accepted request runs 3 * mip_levels + 4 multiplies, one at
// a time, on the single shared 32x16 multiplier before its result is loaded; when
// the settings already make the layout invalid it goes straight to the result.
// One request at a time: a new one is taken once the last result is loaded, which
// waits for the result side to be free. Reset: synchronous, active low; control and
// config registers take reset values; datapath and result registers have none.
module texture_subresource_layout_core
    import tsl_pkg::*;
#(
    parameter int MAX_MIP_LEVELS = 17
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [10:0] i_layer,
    input  logic [2:0]  i_face,
    input  logic [4:0]  i_mip,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_found,
    output logic [63:0] o_offset,
    output logic [63:0] o_level_size,
    output logic [15:0] o_level_width,
    output logic [15:0] o_level_height,
    output logic [15:0] o_level_depth,
    output logic [63:0] o_total_size
);

    localparam int LVL_W = $clog2(MAX_MIP_LEVELS + 1);

    t_cfg     cfg;
    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    t_state     r_state;
    t_state     n_state;
    logic       r_issued;
    logic       n_issued;
    logic [LVL_W-1:0] r_m;
    logic       r_out_valid;

    logic [10:0] r_layer;
    logic [2:0]  r_face;
    logic [4:0]  r_mip;
    logic [63:0] r_prod;
    logic [63:0] r_chain;
    logic [63:0] r_before;
    logic [63:0] r_lsize;
    logic [15:0] r_lw;
    logic [15:0] r_lh;
    logic [15:0] r_ld;
    logic [15:0] r_count;
    logic [63:0] r_total;
    logic        r_ovf;
    logic [15:0] r_idx;
    logic [63:0] r_off;

    logic        r_o_found;
    logic [63:0] r_o_offset;
    logic [63:0] r_o_lsize;
    logic [15:0] r_o_lw;
    logic [15:0] r_o_lh;
    logic [15:0] r_o_ld;
    logic [63:0] r_o_total;

    logic        accept;
    logic        op_state;
    logic        last_lvl;
    logic        at_mip;
    logic        load_out;
    logic        in_range;
    logic        hit;
    logic [15:0] lvl_w;
    logic [15:0] lvl_h;
    logic [15:0] lvl_d;
    logic [15:0] blk_x;
    logic [15:0] blk_y;

    tsl_cfg #(
        .MAX_MIP_LEVELS(MAX_MIP_LEVELS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tsl_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // extents of the level being summed
    assign lvl_w = tsl_extent(cfg.width, 6'(r_m));
    assign lvl_h = tsl_extent(cfg.height, 6'(r_m));
    assign lvl_d = tsl_extent(cfg.depth, 6'(r_m));
    assign blk_x = tsl_blocks(lvl_w, cfg.block_log2);
    assign blk_y = tsl_blocks(lvl_h, cfg.block_log2);

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign op_state   = (r_state != S_IDLE) && (r_state != S_FIN);
    assign last_lvl   = (6'(r_m) + 6'd1) == {1'b0, cfg.mip_levels};
    assign at_mip     = 6'(r_m) == {1'b0, r_mip};
    assign load_out   = (r_state == S_FIN) && (!r_out_valid || i_out_ready);
    assign in_range   = ({1'b0, r_layer} < cfg.array_size) && (r_face < cfg.face_count) &&
                        (r_mip < cfg.mip_levels);
    assign hit        = !r_ovf && in_range;

    // sequencer: next state and multiplier operands
    always_comb begin
        n_state       = r_state;
        n_issued      = r_issued;
        mul_req.start = 1'b0;
        mul_req.a     = 64'd0;
        mul_req.b     = 16'd0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = cfg.layout_ok ? S_L_BPB : S_FIN;
            end
            S_L_BPB: begin
                mul_req.a = 64'(blk_x);
                mul_req.b = 16'(cfg.bpb);
                if (mul_rsp.done) n_state = S_L_BY;
            end
            S_L_BY: begin
                mul_req.a = r_prod;
                mul_req.b = blk_y;
                if (mul_rsp.done) n_state = S_L_D;
            end
            S_L_D: begin
                mul_req.a = r_prod;
                mul_req.b = lvl_d;
                if (mul_rsp.done) n_state = last_lvl ? S_CNT : S_L_BPB;
            end
            S_CNT: begin
                mul_req.a = 64'(cfg.array_size);
                mul_req.b = 16'(cfg.face_count);
                if (mul_rsp.done) n_state = S_TOT;
            end
            S_TOT: begin
                mul_req.a = r_chain;
                mul_req.b = r_count;
                if (mul_rsp.done) n_state = S_IDX;
            end
            S_IDX: begin
                mul_req.a = 64'(r_layer);
                mul_req.b = 16'(cfg.face_count);
                if (mul_rsp.done) n_state = S_OFF;
            end
            S_OFF: begin
                mul_req.a = r_chain;
                mul_req.b = r_idx;
                if (mul_rsp.done) n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // one multiply per operation state
        if (op_state) begin
            mul_req.start = !r_issued;
            if (!r_issued) n_issued = 1'b1;
            if (mul_rsp.done) n_issued = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_m         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
            if (accept) begin
                r_m <= '0;
            end else if (r_state == S_L_D && mul_rsp.done) begin
                r_m <= r_m + LVL_W'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_layer <= i_layer;
            r_face  <= i_face;
            r_mip   <= i_mip;
            r_chain <= 64'd0;
            r_ovf   <= !cfg.layout_ok;
        end
        if (mul_rsp.done) begin
            case (r_state) inside
                S_L_BPB, S_L_BY: r_prod <= mul_rsp.p[63:0];
                S_L_D: begin
                    r_chain <= r_chain + mul_rsp.p[63:0];
                    if (at_mip) begin
                        r_before <= r_chain;
                        r_lsize  <= mul_rsp.p[63:0];
                        r_lw     <= lvl_w;
                        r_lh     <= lvl_h;
                        r_ld     <= lvl_d;
                    end
                end
                S_CNT: r_count <= mul_rsp.p[15:0];
                S_TOT: begin
                    r_total <= mul_rsp.p[63:0];
                    r_ovf   <= |mul_rsp.p[79:64];
                end
                S_IDX: r_idx <= mul_rsp.p[15:0] + 16'(r_face);
                S_OFF: r_off <= mul_rsp.p[63:0] + r_before;
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_found  <= hit;
            r_o_offset <= hit ? r_off : 64'd0;
            r_o_lsize  <= hit ? r_lsize : 64'd0;
            r_o_lw     <= hit ? r_lw : 16'd0;
            r_o_lh     <= hit ? r_lh : 16'd0;
            r_o_ld     <= hit ? r_ld : 16'd0;
            r_o_total  <= r_ovf ? 64'd0 : r_total;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_o_found;
    assign o_offset       = r_o_offset;
    assign o_level_size   = r_o_lsize;
    assign o_level_width  = r_o_lw;
    assign o_level_height = r_o_lh;
    assign o_level_depth  = r_o_ld;
    assign o_total_size   = r_o_total;

`ifndef SYNTHESIS
    // multiplier answers only a request that was issued
    a_done_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> r_issued)
        else $error("multiplier done without a pending request");

    // an accepted request leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after accept");

    // a found subresource has nonzero total size, level size and level width
    a_found_sizes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_total_size != 64'd0 && o_level_size != 64'd0 &&
                                      o_level_width != 16'd0))
        else $error("found result with zero size");
`endif

endmodule

[verif/subresource_layout_checker.sv]
module subresource_layout_checker
    import tsl_pkg::*;
#(
    parameter int MAX_MIP_LEVELS = 17
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [10:0] i_layer,
    input  logic [2:0]  i_face,
    input  logic [4:0]  i_mip,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_found,
    input  logic [63:0] i_offset,
    input  logic [63:0] i_level_size,
    input  logic [15:0] i_level_width,
    input  logic [15:0] i_level_height,
    input  logic [15:0] i_level_depth,
    input  logic [63:0] i_total_size,
    output int          o_fail_count,
    output int          o_pending
);

    // one predicted answer per accepted request
    typedef struct packed {
        logic        found;
        logic [63:0] offset;
        logic [63:0] level_size;
        logic [15:0] level_width;
        logic [15:0] level_height;
        logic [15:0] level_depth;
        logic [63:0] total_size;
    } t_answer;

    t_cfg    shadow;
    t_answer pending_answers[$];

    // max(1, base >> m)
    function automatic logic [63:0] mip_extent(logic [15:0] base, int m);
        logic [15:0] v;
        v = (m < 16) ? (base >> m) : 16'd0;
        return (v == 16'd0) ? 64'd1 : 64'(v);
    endfunction

    // blocks across * bytes per block * blocks down * depth
    function automatic logic [63:0] mip_bytes(t_cfg c, int m);
        logic [63:0] span;
        logic [63:0] bx;
        logic [63:0] by;
        span = (64'd1 << c.block_log2) - 64'd1;
        bx   = (mip_extent(c.width, m) + span) >> c.block_log2;
        by   = (mip_extent(c.height, m) + span) >> c.block_log2;
        return bx * 64'(c.bpb) * by * mip_extent(c.depth, m);
    endfunction

    // packed layout: layer, then face, then mip fastest
    function automatic t_answer locate_subresource(t_cfg c, logic [10:0] layer,
                                                   logic [2:0] face, logic [4:0] mip);
        t_answer      a;
        logic [63:0]  chain;
        logic [63:0]  below;
        logic [63:0]  count;
        logic [127:0] prod;
        a     = '0;
        chain = '0;
        below = '0;
        if (c.bpb == 5'd0 || c.block_log2 == BLOCK_LOG2_UNKNOWN ||
            c.width == 16'd0 || c.height == 16'd0 || c.depth == 16'd0 ||
            c.mip_levels == 5'd0 || int'(c.mip_levels) > MAX_MIP_LEVELS ||
            c.face_count == 3'd0 || c.array_size == 12'd0)
            return a;
        for (int m = 0; m < int'(c.mip_levels); m++) begin
            if (m == int'(mip))
                below = chain;
            chain = chain + mip_bytes(c, m);
        end
        count = 64'(c.array_size) * 64'(c.face_count);
        prod  = 128'(chain) * 128'(count);
        // whole image must fit in 64 bits
        if (prod[127:64] != '0)
            return a;
        a.total_size = prod[63:0];
        if (layer >= 11'(c.array_size > 12'd2047 ? 12'd2047 : c.array_size) &&
            !(c.array_size > 12'd2047))
            return a;
        if (face >= c.face_count || mip >= c.mip_levels)
            return a;
        a.found        = 1'b1;
        a.offset       = (64'(layer) * 64'(c.face_count) + 64'(face)) * chain + below;
        a.level_size   = mip_bytes(c, int'(mip));
        a.level_width  = 16'(mip_extent(c.width, int'(mip)));
        a.level_height = 16'(mip_extent(c.height, int'(mip)));
        a.level_depth  = 16'(mip_extent(c.depth, int'(mip)));
        return a;
    endfunction

    task automatic note_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count = o_fail_count + 1;
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // register shadow, prediction at request accept, compare at result accept
    always @(posedge i_clk) begin : monitor
        t_answer want;
        int      delta;
        delta = 0;
        if (!i_rst_n) begin
            shadow            = '0;
            shadow.bpb        = 5'd4;
            shadow.width      = 16'd1;
            shadow.height     = 16'd1;
            shadow.depth      = 16'd1;
            shadow.mip_levels = 5'd1;
            shadow.face_count = 3'd1;
            shadow.array_size = 12'd1;
            pending_answers.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_BLOCK_LOG2:  shadow.block_log2 = i_cfg_data[1:0];
                    CFG_BYTES_BLOCK: shadow.bpb        = i_cfg_data[4:0];
                    CFG_WIDTH:       shadow.width      = i_cfg_data;
                    CFG_HEIGHT:      shadow.height     = i_cfg_data;
                    CFG_DEPTH:       shadow.depth      = i_cfg_data;
                    CFG_MIP_LEVELS:  shadow.mip_levels = i_cfg_data[4:0];
                    CFG_FACE_COUNT:  shadow.face_count = i_cfg_data[2:0];
                    CFG_ARRAY_SIZE:  shadow.array_size = i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_answers.size() == 0) begin
                    note_mismatch("result with no request outstanding");
                end else begin
                    want  = pending_answers.pop_front();
                    delta = delta - 1;
                    check_field("found", 64'(i_found), 64'(want.found));
                    check_field("offset", i_offset, want.offset);
                    check_field("level_size", i_level_size, want.level_size);
                    check_field("level_width", 64'(i_level_width), 64'(want.level_width));
                    check_field("level_height", 64'(i_level_height), 64'(want.level_height));
                    check_field("level_depth", 64'(i_level_depth), 64'(want.level_depth));
                    check_field("total_size", i_total_size, want.total_size);
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_answers.insert(pending_answers.size(),
                                       locate_subresource(shadow, i_layer, i_face, i_mip));
                delta = delta + 1;
            end
            o_pending <= o_pending + delta;
        end
    end

endmodule

[verif/tb_texture_subresource_layout_core.sv]
module tb_texture_subresource_layout_core;
    import tsl_pkg::*;

    localparam int MIP_CAP     = 17;
    localparam int LIMIT       = 2000000;
    localparam int LONG_HOLD   = 600;
    localparam int PHASES      = 16;
    localparam int PHASE_ITEMS = 62;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic [2:0]  i_cfg_addr     = '0;
    logic [15:0] i_cfg_data     = '0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [10:0] i_layer        = '0;
    logic [2:0]  i_face         = '0;
    logic [4:0]  i_mip          = '0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic        o_found;
    logic [63:0] o_offset;
    logic [63:0] o_level_size;
    logic [15:0] o_level_width;
    logic [15:0] o_level_height;
    logic [15:0] o_level_depth;
    logic [63:0] o_total_size;

    logic hold_kick      = 1'b0;
    int   hold_left      = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   cycle_count    = 0;
    int   fail_count;
    int   pending;
    t_cfg cur;

    texture_subresource_layout_core #(
        .MAX_MIP_LEVELS(MIP_CAP)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_layer       (i_layer),
        .i_face        (i_face),
        .i_mip         (i_mip),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_offset      (o_offset),
        .o_level_size  (o_level_size),
        .o_level_width (o_level_width),
        .o_level_height(o_level_height),
        .o_level_depth (o_level_depth),
        .o_total_size  (o_total_size)
    );

    subresource_layout_checker #(
        .MAX_MIP_LEVELS(MIP_CAP)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_layer       (i_layer),
        .i_face        (i_face),
        .i_mip         (i_mip),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_found       (o_found),
        .i_offset      (o_offset),
        .i_level_size  (o_level_size),
        .i_level_width (o_level_width),
        .i_level_height(o_level_height),
        .i_level_depth (o_level_depth),
        .i_total_size  (o_total_size),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_left   <= 0;
        end else if (hold_kick) begin
            i_out_ready <= 1'b0;
            hold_left   <= LONG_HOLD;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin : watchdog
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count = cycle_count + 1;
        end
        $display("texture_subresource_layout_core verification failed");
        $finish;
    end

    // one query request; returns at the edge where it is accepted
    task automatic send_query(logic [10:0] layer, logic [2:0] face, logic [4:0] mip);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_layer    <= layer;
        i_face     <= face;
        i_mip      <= mip;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // drop valid and wait for every outstanding answer
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // sometimes set junk above the register width; the block ignores it
    function automatic logic [15:0] pad(logic [15:0] value, int bits);
        logic [15:0] junk;
        junk = 16'($urandom);
        if (bits < 16 && $urandom_range(0, 3) == 0)
            return value | (junk << bits);
        return value;
    endfunction

    task automatic apply_layout(t_cfg c);
        write_reg(CFG_BLOCK_LOG2, pad(16'(c.block_log2), 2));
        write_reg(CFG_BYTES_BLOCK, pad(16'(c.bpb), 5));
        write_reg(CFG_WIDTH, c.width);
        write_reg(CFG_HEIGHT, c.height);
        write_reg(CFG_DEPTH, c.depth);
        write_reg(CFG_MIP_LEVELS, pad(16'(c.mip_levels), 5));
        write_reg(CFG_FACE_COUNT, pad(16'(c.face_count), 3));
        write_reg(CFG_ARRAY_SIZE, pad(16'(c.array_size), 12));
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_cfg make_layout(int bl, int bpb, int w, int h, int d,
                                         int mips, int faces, int layers);
        t_cfg c;
        c            = '0;
        c.block_log2 = 2'(bl);
        c.bpb        = 5'(bpb);
        c.width      = 16'(w);
        c.height     = 16'(h);
        c.depth      = 16'(d);
        c.mip_levels = 5'(mips);
        c.face_count = 3'(faces);
        c.array_size = 12'(layers);
        return c;
    endfunction

    function automatic logic [15:0] rand_extent();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 16'd0;
        if (r < 60)
            return 16'($urandom_range(1, 64));
        if (r < 85)
            return 16'($urandom_range(65, 4096));
        return 16'($urandom_range(4097, 65535));
    endfunction

    // mostly usable layouts with small mip chains, a few broken ones
    function automatic t_cfg random_layout();
        t_cfg c;
        int   r;
        c = '0;
        c.block_log2 = ($urandom_range(0, 99) < 3) ? BLOCK_LOG2_UNKNOWN
                                                   : 2'($urandom_range(0, 2));
        r = $urandom_range(0, 99);
        c.bpb = (r < 3) ? 5'd0 : (r < 15) ? 5'($urandom_range(17, 31))
                                          : 5'($urandom_range(1, 16));
        c.width  = rand_extent();
        c.height = rand_extent();
        c.depth  = rand_extent();
        r = $urandom_range(0, 99);
        c.mip_levels = (r < 3) ? 5'd0 : (r < 6) ? 5'($urandom_range(18, 31))
                     : (r < 80) ? 5'($urandom_range(1, 5)) : 5'($urandom_range(6, 17));
        r = $urandom_range(0, 99);
        c.face_count = (r < 3) ? 3'd0 : (r < 15) ? 3'd7 : 3'($urandom_range(1, 6));
        r = $urandom_range(0, 99);
        c.array_size = (r < 3) ? 12'd0 : (r < 75) ? 12'($urandom_range(1, 8))
                                                  : 12'($urandom_range(9, 4095));
        return c;
    endfunction

    // mostly in-range queries, the rest any bit pattern
    task automatic random_query(t_cfg c);
        logic [10:0] layer;
        logic [2:0]  face;
        logic [4:0]  mip;
        if ($urandom_range(0, 99) < 80 && c.array_size != 12'd0 &&
            c.face_count != 3'd0 && c.mip_levels != 5'd0) begin
            layer = 11'($urandom_range(0, (c.array_size > 12'd2048) ? 2047
                                                                   : int'(c.array_size) - 1));
            face  = 3'($urandom_range(0, int'(c.face_count) - 1));
            mip   = 5'($urandom_range(0, int'(c.mip_levels) - 1));
        end else begin
            layer = 11'($urandom);
            face  = 3'($urandom);
            mip   = 5'($urandom);
        end
        send_query(layer, face, mip);
    endtask

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: one texel, plus a query far out of range
        send_query(11'd0, 3'd0, 5'd0);
        send_query(11'h7FF, 3'h7, 5'h1F);
        settle();

        // largest compressed array with a full mip chain
        cur = make_layout(2, 16, 65535, 65535, 1, 17, 6, 2048);
        apply_layout(cur);
        send_query(11'd0, 3'd0, 5'd0);
        send_query(11'd2047, 3'd5, 5'd16);
        send_query(11'd2047, 3'd6, 5'd0);
        send_query(11'd0, 3'd0, 5'd17);
        send_query(11'd1, 3'd3, 5'd5);
        settle();

        // whole image does not fit in 64 bits
        cur = make_layout(0, 31, 65535, 65535, 65535, 17, 7, 4095);
        apply_layout(cur);
        send_query(11'd0, 3'd0, 5'd0);
        send_query(11'd100, 3'd2, 5'd4);
        settle();

        // seven faces, oversized array and bytes per block, still valid
        cur = make_layout(1, 31, 3, 5, 2, 3, 7, 4095);
        apply_layout(cur);
        send_query(11'd2047, 3'd6, 5'd2);
        send_query(11'd0, 3'd0, 5'd3);
        send_query(11'd1, 3'd7, 5'd0);
        settle();

        // each zero setting, unknown block size, too many mips
        for (int k = 0; k < 10; k++) begin
            cur = make_layout(1, 8, 40, 24, 3, 4, 2, 3);
            case (k)
                0: cur.bpb        = 5'd0;
                1: cur.width      = 16'd0;
                2: cur.height     = 16'd0;
                3: cur.depth      = 16'd0;
                4: cur.mip_levels = 5'd0;
                5: cur.face_count = 3'd0;
                6: cur.array_size = 12'd0;
                7: cur.block_log2 = BLOCK_LOG2_UNKNOWN;
                8: cur.mip_levels = 5'd18;
                default: cur.mip_levels = 5'd31;
            endcase
            apply_layout(cur);
            send_query(11'd1, 3'd1, 5'd1);
            settle();
        end

        // random layouts, cycling through the idle patterns
        for (int p = 0; p < PHASES; p++) begin
            cur = random_layout();
            apply_layout(cur);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            if (p == 4) begin
                hold_kick <= 1'b1;
                @(posedge i_clk);
                hold_kick <= 1'b0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_query(cur);
            settle();
        end

        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("texture_subresource_layout_core verification clean");
        end else begin
            $display("texture_subresource_layout_core verification failed");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/tsl_pkg.sv
hw/rtl/tsl_cfg.sv
hw/rtl/tsl_mul.sv
hw/rtl/texture_subresource_layout_core.sv
verif/subresource_layout_checker.sv
verif/tb_texture_subresource_layout_core.sv
